// ===== sv/smmp_pkg.sv =====
// package: payload words, opcodes, register indexes and fixed widths of the gemm unit
`timescale 1ns / 1ps

package smmp_pkg;

    // fixed field widths
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int OP_W      = 2;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int VEC_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_CFG_W = 5;
    localparam int VEC_CFG_W = 3;

    // input word opcodes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_X = 2'd1,
        OP_WRITE_Y = 2'd2,
        OP_RUN     = 2'd3
    } t_opcode;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_PRODUCT  = 3'd0,
        CFG_SCALE_PREVIOUS = 3'd1,
        CFG_ROWS_IN_USE    = 3'd2,
        CFG_COLS_IN_USE    = 3'd3,
        CFG_VECTORS_IN_USE = 3'd4
    } t_cfg_index;

    // register reset values
    localparam logic signed [VALUE_W-1:0] SCALE_PRODUCT_RST  = 32'sd65536;
    localparam logic signed [VALUE_W-1:0] SCALE_PREVIOUS_RST = 32'sd0;
    localparam logic [DIM_CFG_W-1:0]      ROWS_RST           = 5'd16;
    localparam logic [DIM_CFG_W-1:0]      COLS_RST           = 5'd16;
    localparam logic [VEC_CFG_W-1:0]      VECS_RST           = 3'd1;

    // input word
    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [ROW_W-1:0]          row_index;
        logic [COL_W-1:0]          col_index;
        logic signed [VALUE_W-1:0] element_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [ROW_W-1:0]          out_row;
        logic [VEC_W-1:0]          out_vector;
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
    } t_out_word;

endpackage

// ===== sv/scaled_matrix_multivector_product_unit.sv =====
// top level: y = c_y*y + c_a*A*x on local stores with one shared 33x33 multiplier
// load words are written straight into the stores while idle; the length of a run is
// set by the shared multiplier: one multiply-accumulate per cycle over the columns,
// then three partial products for the c_a scaling and a few rounding steps per element
// results leave through an output register; a run may continue while one result waits
// reset (sync, active low) clears the sequencer and the output valid and restores the
// registers; the A, x and y stores are not cleared and hold garbage until written
`timescale 1ns / 1ps

module scaled_matrix_multivector_product_unit #(
    parameter int MAX_DIM     = 16,
    parameter int MAX_VECTORS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [smmp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [smmp_pkg::VALUE_W-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  smmp_pkg::t_in_word                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output smmp_pkg::t_out_word                   o_out_data
);
    import smmp_pkg::*;

    // derived sizes
    localparam int IW      = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int KW      = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int VCW     = $clog2(MAX_VECTORS + 1);
    localparam int A_DEPTH = MAX_DIM * MAX_DIM;
    localparam int AAW     = $clog2(A_DEPTH);
    localparam int V_DEPTH = MAX_VECTORS * MAX_DIM;
    localparam int VAW     = $clog2(V_DEPTH);
    localparam int OPD_W   = VALUE_W + 1;
    localparam int PROD_W  = 2 * OPD_W;
    localparam int ACC_W   = 2 * VALUE_W + $clog2(MAX_DIM);
    localparam int NCHUNK  = (ACC_W + VALUE_W - 1) / VALUE_W;
    localparam int CW      = $clog2(NCHUNK);
    localparam int EXT_W   = NCHUNK * VALUE_W;
    localparam int PW      = EXT_W + VALUE_W;
    localparam int TW      = PW - 2 * FRAC_BITS;
    localparam int YS_W    = PROD_W - FRAC_BITS;

    localparam logic signed [PROD_W-1:0] HALF_Y    = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0]     HALF_TERM = PW'(1) <<< (2 * FRAC_BITS - 1);

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_YRD  = 9'b000000010,
        S_YMUL = 9'b000000100,
        S_YRND = 9'b000001000,
        S_MAC  = 9'b000010000,
        S_CMUL = 9'b000100000,
        S_CADD = 9'b001000000,
        S_RND  = 9'b010000000,
        S_SUM  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic signed [VALUE_W-1:0] r_scale_prod, r_scale_prev;
    logic [DIM_CFG_W-1:0]      r_rows_cfg, r_cols_cfg;
    logic [VEC_CFG_W-1:0]      r_vecs_cfg;

    // run limits and counters
    logic [DIM_W-1:0] r_rows, r_cols, r_j;
    logic [VCW-1:0]   r_vecs;
    logic [IW-1:0]    r_i;
    logic [KW-1:0]    r_k;
    logic [CW-1:0]    r_c, r_pc;
    logic             r_rd_vld, r_mul_vld;

    // datapath registers
    logic signed [VALUE_W-1:0] r_adata, r_xdata, r_ydata, r_ys;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PW-1:0]      r_wide;
    logic signed [TW-1:0]      r_term;
    logic                      r_out_vld;
    t_out_word                 r_out;

    // local stores
    logic signed [VALUE_W-1:0] mem_a [0:A_DEPTH-1];
    logic signed [VALUE_W-1:0] mem_x [0:V_DEPTH-1];
    logic signed [VALUE_W-1:0] mem_y [0:V_DEPTH-1];

    logic in_acc, is_run, out_take, out_free;
    logic issuing, mac_done, chunk_last, row_last, vec_last;
    logic [DIM_W-1:0] run_rows, run_cols;
    logic [VCW-1:0]   run_vecs;

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign is_run      = in_acc & (i_in_data.opcode == OP_RUN);
    assign out_take    = r_out_vld & ~i_out_stall;
    assign out_free    = ~r_out_vld | ~i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // loop status
    assign issuing    = (r_j != r_cols);
    assign mac_done   = ~issuing & ~r_rd_vld & ~r_mul_vld;
    assign chunk_last = (r_c == CW'(NCHUNK - 1));
    assign row_last   = (int'(r_i) + 1 == int'(r_rows));
    assign vec_last   = (int'(r_k) + 1 == int'(r_vecs));

    // clamp run dimensions
    always_comb begin
        int rv;
        int cv;
        int vv;
        rv = int'(r_rows_cfg);
        cv = int'(r_cols_cfg);
        vv = int'(r_vecs_cfg);
        if (rv < 1) rv = 1;
        else if (rv > MAX_DIM) rv = MAX_DIM;
        if (cv < 1) cv = 1;
        else if (cv > MAX_DIM) cv = MAX_DIM;
        if (vv < 1) vv = 1;
        else if (vv > MAX_VECTORS) vv = MAX_VECTORS;
        run_rows = DIM_W'(rv);
        run_cols = DIM_W'(cv);
        run_vecs = VCW'(vv);
    end

    // store addressing for load words
    int  ld_row, ld_col;
    logic a_we, x_we, y_ld;
    logic [AAW-1:0] a_waddr, a_raddr;
    logic [VAW-1:0] x_waddr, x_raddr, y_waddr, y_raddr, y_ld_addr;
    logic           y_we;
    logic signed [VALUE_W-1:0] y_wdata;

    assign ld_row    = int'(i_in_data.row_index);
    assign ld_col    = int'(i_in_data.col_index);
    assign a_we      = in_acc && (i_in_data.opcode == OP_WRITE_A)
                       && ld_row < MAX_DIM && ld_col < MAX_DIM;
    assign x_we      = in_acc && (i_in_data.opcode == OP_WRITE_X)
                       && ld_row < MAX_DIM && ld_col < MAX_VECTORS;
    assign y_ld      = in_acc && (i_in_data.opcode == OP_WRITE_Y)
                       && ld_row < MAX_DIM && ld_col < MAX_VECTORS;
    assign a_waddr   = AAW'(ld_row * MAX_DIM + ld_col);
    assign x_waddr   = VAW'(ld_col * MAX_DIM + ld_row);
    assign y_ld_addr = VAW'(ld_col * MAX_DIM + ld_row);

    // store addressing for the run
    assign a_raddr = AAW'(int'(r_i) * MAX_DIM + int'(r_j[IW-1:0]));
    assign x_raddr = VAW'(int'(r_k) * MAX_DIM + int'(r_j[IW-1:0]));
    assign y_raddr = VAW'(int'(r_k) * MAX_DIM + int'(r_i));

    // y store write: load word or result writeback
    logic signed [VALUE_W-1:0] sum_sat;
    assign y_we    = y_ld | ((r_state == S_SUM) & out_free);
    assign y_waddr = (r_state == S_SUM) ? y_raddr : y_ld_addr;
    assign y_wdata = (r_state == S_SUM) ? sum_sat : i_in_data.element_value;

    // stores, read data registered
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[a_waddr] <= i_in_data.element_value;
        end
        r_adata <= mem_a[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            mem_x[x_waddr] <= i_in_data.element_value;
        end
        r_xdata <= mem_x[x_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (y_we) begin
            mem_y[y_waddr] <= y_wdata;
        end
        r_ydata <= mem_y[y_raddr];
    end

    // shared multiplier operand select
    logic signed [EXT_W-1:0]   acc_ext;
    logic [VALUE_W-1:0]        chunk_bits;
    logic signed [OPD_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    assign acc_ext    = EXT_W'(r_acc);
    assign chunk_bits = acc_ext[VALUE_W * r_c +: VALUE_W];

    always_comb begin
        case (r_state)
            S_YMUL: begin
                mul_a = OPD_W'(r_scale_prev);
                mul_b = OPD_W'(r_ydata);
            end
            S_CMUL: begin
                // lower chunks unsigned, top chunk carries the sign
                mul_a = {chunk_last & chunk_bits[VALUE_W-1], chunk_bits};
                mul_b = OPD_W'(r_scale_prod);
            end
            default: begin
                mul_a = OPD_W'(r_adata);
                mul_b = OPD_W'(r_xdata);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // scaled y: round half up and saturate
    logic signed [PROD_W-1:0] ys_sum;
    logic signed [YS_W-1:0]   ys_shift;
    logic [YS_W-VALUE_W:0]    ys_top;
    logic signed [VALUE_W-1:0] ys_sat;

    assign ys_sum   = r_prod + HALF_Y;
    assign ys_shift = YS_W'(ys_sum >>> FRAC_BITS);
    assign ys_top   = ys_shift[YS_W-1:VALUE_W-1];
    assign ys_sat   = (&ys_top | ~|ys_top) ? ys_shift[VALUE_W-1:0]
                    : {ys_shift[YS_W-1], {(VALUE_W-1){~ys_shift[YS_W-1]}}};

    // partial product placed by chunk
    logic signed [PW-1:0] pp_ext, pp_sh, wide_next;
    assign pp_ext    = PW'(r_prod);
    assign pp_sh     = pp_ext <<< (VALUE_W * r_pc);
    assign wide_next = r_wide + pp_sh;

    // product term rounding
    logic signed [PW-1:0] term_full;
    logic signed [TW-1:0] term_sh;
    assign term_full = r_wide + HALF_TERM;
    assign term_sh   = TW'(term_full >>> (2 * FRAC_BITS));

    // final sum and saturation
    logic signed [TW:0]       sum_full;
    logic [TW-VALUE_W+1:0]    sum_top;
    assign sum_full = (TW+1)'(r_term) + (TW+1)'(r_ys);
    assign sum_top  = sum_full[TW:VALUE_W-1];
    assign sum_sat  = (&sum_top | ~|sum_top) ? sum_full[VALUE_W-1:0]
                    : {sum_full[TW], {(VALUE_W-1){~sum_full[TW]}}};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (is_run) n_state = S_YRD;
            S_YRD:  n_state = S_YMUL;
            S_YMUL: n_state = S_YRND;
            S_YRND: n_state = S_MAC;
            S_MAC:  if (mac_done) n_state = S_CMUL;
            S_CMUL: n_state = S_CADD;
            S_CADD: n_state = chunk_last ? S_RND : S_CMUL;
            S_RND:  n_state = S_SUM;
            S_SUM: begin
                if (out_free) n_state = (row_last && vec_last) ? S_IDLE : S_YRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scale_prod <= SCALE_PRODUCT_RST;
            r_scale_prev <= SCALE_PREVIOUS_RST;
            r_rows_cfg   <= ROWS_RST;
            r_cols_cfg   <= COLS_RST;
            r_vecs_cfg   <= VECS_RST;
            r_rows       <= '0;
            r_cols       <= '0;
            r_vecs       <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_j          <= '0;
            r_c          <= '0;
            r_pc         <= '0;
            r_rd_vld     <= 1'b0;
            r_mul_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCALE_PRODUCT:  r_scale_prod <= i_cfg_data;
                    CFG_SCALE_PREVIOUS: r_scale_prev <= i_cfg_data;
                    CFG_ROWS_IN_USE:    r_rows_cfg   <= i_cfg_data[DIM_CFG_W-1:0];
                    CFG_COLS_IN_USE:    r_cols_cfg   <= i_cfg_data[DIM_CFG_W-1:0];
                    CFG_VECTORS_IN_USE: r_vecs_cfg   <= i_cfg_data[VEC_CFG_W-1:0];
                    default: ;
                endcase
            end

            // mac read/multiply pipeline flags
            r_rd_vld  <= (r_state == S_MAC) & issuing;
            r_mul_vld <= r_rd_vld;

            case (r_state)
                S_IDLE: begin
                    if (is_run) begin
                        r_rows <= run_rows;
                        r_cols <= run_cols;
                        r_vecs <= run_vecs;
                        r_i    <= '0;
                        r_k    <= '0;
                    end
                end
                S_YRND: begin
                    r_j <= '0;
                    r_c <= '0;
                end
                S_MAC: begin
                    if (issuing) r_j <= r_j + 1'b1;
                end
                S_CMUL: r_pc <= r_c;
                S_CADD: r_c <= r_c + 1'b1;
                S_SUM: begin
                    if (out_free) begin
                        if (row_last) begin
                            r_i <= '0;
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // output word valid
            if ((r_state == S_SUM) && out_free) r_out_vld <= 1'b1;
            else if (out_take) r_out_vld <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_YRND: begin
                r_ys   <= (r_scale_prev != '0) ? ys_sat : '0;
                r_acc  <= '0;
                r_wide <= '0;
            end
            S_MAC: begin
                if (r_mul_vld) r_acc <= r_acc + ACC_W'(r_prod);
            end
            S_CADD: r_wide <= wide_next;
            S_RND:  r_term <= term_sh;
            S_SUM: begin
                if (out_free) begin
                    r_out.out_row    <= ROW_W'(r_i);
                    r_out.out_vector <= VEC_W'(r_k);
                    r_out.out_value  <= sum_sat;
                    r_out.out_last   <= row_last & vec_last;
                end
            end
            default: ;
        endcase
    end

endmodule
